// ===== hw/rtl/gtoe_pkg.sv =====
// gtoe_pkg: shared constants, types and the arctangent table function
// for the geodetic to ecef converter; no dependencies
package gtoe_pkg;

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int SQRT_BITS = 61;   // bits of the square root result
  localparam int QUO_BITS  = 62;   // bits of the quotient
  localparam int REM_W     = 122;  // square root remainder width
  localparam int NUM_W     = 101;  // dividend width, axis times 2^68
  localparam int DSH_W     = 123;  // shifted divisor width
  localparam int RMUL_LAT  = 4;    // latency of the rounding multiplier

  localparam logic signed [63:0] ONE_Q60      = 64'sh1000_0000_0000_0000;
  localparam logic signed [63:0] INV_GAIN_Q60 = 64'sd700114967507363220;
  localparam logic [63:0]        TWO_PI_Q60   = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0]        INT64_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] XYZ_MAX      = 64'sd17179869183;
  localparam logic signed [63:0] XYZ_MIN      = -64'sd17179869184;
  localparam logic [32:0]        AXIS_RESET   = 33'd6378137000;
  localparam logic [39:0]        ECC_RESET    = 40'd7360548637;
  localparam logic [32:0]        AXIS_MAX     = 33'h1_FFFF_FFFF;

  typedef enum logic {
    REG_AXIS = 1'b0,
    REG_ECC  = 1'b1
  } reg_idx_t;

  // one cordic rotation lane
  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic [63:0]        z;
    logic               flip;
  } lane_t;

  // per item data that rides alongside the radius datapath
  typedef struct packed {
    logic signed [63:0] clat;
    logic signed [63:0] slat;
    logic signed [63:0] clon;
    logic signed [63:0] slon;
    logic signed [31:0] h;
  } side_t;

  // bitwise long division, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      q = {q[62:0], 1'b0};
      if (r >= d) begin
        r = r - d;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-i in turns, 2^64 a full turn
  function automatic logic [63:0] atan_turns(input int i);
    logic [63:0] acc;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] t;
    int sh;
    acc = '0;
    q = '0;
    if (i == 0) return 64'd1 << 61;
    for (int k = 0; k < 32; k++) begin
      sh = i * (2 * k + 1);
      if (sh <= 62) begin
        t = udiv64(64'd1 << (62 - sh), 64'(2 * k + 1));
        if ((k % 2) == 0) acc = acc + t;
        else acc = acc - t;
      end
    end
    r = acc;
    for (int n = 0; n < 62; n++) begin
      r = r << 1;
      q = q << 1;
      if (r >= TWO_PI_Q60) begin
        r = r - TWO_PI_Q60;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

// ===== hw/rtl/gtoe_in_if.sv =====
// gtoe_in_if: input channel carrying one geodetic position per item
// depends on nothing
interface gtoe_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] latitude_angle;
  logic signed [31:0] longitude_angle;
  logic signed [31:0] height_mm;

  modport source (output valid, latitude_angle, longitude_angle, height_mm, input ready);
  modport sink   (input valid, latitude_angle, longitude_angle, height_mm, output ready);
endinterface

// ===== hw/rtl/gtoe_out_if.sv =====
// gtoe_out_if: result channel carrying ecef coordinates and the vertical radius
// depends on nothing
interface gtoe_out_if;
  logic               valid;
  logic               ready;
  logic signed [34:0] ecef_x_mm;
  logic signed [34:0] ecef_y_mm;
  logic signed [34:0] ecef_z_mm;
  logic [32:0]        vertical_radius_mm;

  modport source (output valid, ecef_x_mm, ecef_y_mm, ecef_z_mm, vertical_radius_mm,
                  input ready);
  modport sink   (input valid, ecef_x_mm, ecef_y_mm, ecef_z_mm, vertical_radius_mm,
                  output ready);
endinterface

// ===== hw/rtl/gtoe_cordic_cell.sv =====
// gtoe_cordic_cell: one rotation stage of the sine/cosine cordic row
// depends on gtoe_pkg (lane_t, atan_turns)
module gtoe_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            en,
  input  gtoe_pkg::lane_t lane_i,
  output gtoe_pkg::lane_t lane_o
);

  localparam logic [63:0] ATAN = gtoe_pkg::atan_turns(STAGE);

  gtoe_pkg::lane_t    lane_r, lane_nxt;
  logic signed [63:0] xs, ys;

  // rotate toward zero residual angle
  always_comb begin
    xs = lane_i.x >>> STAGE;
    ys = lane_i.y >>> STAGE;
    lane_nxt.flip = lane_i.flip;
    if (lane_i.z[63]) begin
      lane_nxt.x = lane_i.x + ys;
      lane_nxt.y = lane_i.y - xs;
      lane_nxt.z = lane_i.z + ATAN;
    end else begin
      lane_nxt.x = lane_i.x - ys;
      lane_nxt.y = lane_i.y + xs;
      lane_nxt.z = lane_i.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) lane_r <= lane_nxt;
  end

  assign lane_o = lane_r;

endmodule

// ===== hw/rtl/gtoe_sqrt_cell.sv =====
// gtoe_sqrt_cell: one result bit of the pipelined restoring square root
// depends on gtoe_pkg (widths)
module gtoe_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [gtoe_pkg::REM_W-1:0]      rem_i,
  input  logic [gtoe_pkg::SQRT_BITS-1:0]  root_i,
  output logic [gtoe_pkg::REM_W-1:0]      rem_o,
  output logic [gtoe_pkg::SQRT_BITS-1:0]  root_o
);

  localparam int RW = gtoe_pkg::REM_W;

  logic [RW-1:0] trial;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [gtoe_pkg::SQRT_BITS-1:0] root_r, root_nxt;

  // (r + 2^b)^2 - r^2 against the remainder
  always_comb begin
    trial = (RW'(root_i) << (BIT + 1)) + (RW'(1) << (2 * BIT));
    rem_nxt = rem_i;
    root_nxt = root_i;
    if (trial <= rem_i) begin
      rem_nxt = rem_i - trial;
      root_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o = rem_r;
  assign root_o = root_r;

endmodule

// ===== hw/rtl/gtoe_div_cell.sv =====
// gtoe_div_cell: one quotient bit of the pipelined restoring divider
// depends on gtoe_pkg (widths)
module gtoe_div_cell #(
  parameter int BIT = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [gtoe_pkg::NUM_W-1:0]     rem_i,
  input  logic [gtoe_pkg::QUO_BITS-1:0]  quo_i,
  input  logic [gtoe_pkg::SQRT_BITS-1:0] den_i,
  output logic [gtoe_pkg::NUM_W-1:0]     rem_o,
  output logic [gtoe_pkg::QUO_BITS-1:0]  quo_o,
  output logic [gtoe_pkg::SQRT_BITS-1:0] den_o
);

  localparam int DW = gtoe_pkg::DSH_W;

  logic [DW-1:0] dsh;
  logic [gtoe_pkg::NUM_W-1:0] rem_r, rem_nxt;
  logic [gtoe_pkg::QUO_BITS-1:0] quo_r, quo_nxt;
  logic [gtoe_pkg::SQRT_BITS-1:0] den_r;

  // subtract the divisor shifted to this bit when it fits
  always_comb begin
    dsh = DW'(den_i) << BIT;
    rem_nxt = rem_i;
    quo_nxt = quo_i;
    if (DW'(rem_i) >= dsh) begin
      rem_nxt = rem_i - dsh[gtoe_pkg::NUM_W-1:0];
      quo_nxt[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      den_r <= den_i;
    end
  end

  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign den_o = den_r;

endmodule

// ===== hw/rtl/gtoe_rmul.sv =====
// gtoe_rmul: signed 64 by 64 multiply, scaled down by 2^SHIFT with rounding
// half away from zero and saturation; four stages, depends on gtoe_pkg
module gtoe_rmul #(
  parameter int SHIFT = 60
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic signed [63:0] p_o
);

  localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);

  logic [63:0]  ua_r, ub_r;
  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] sum_r;
  logic [2:0]   neg_r;
  logic signed [63:0] p_r;
  logic [127:0] q;
  logic [63:0]  m;

  // final scale and saturate
  always_comb begin
    q = sum_r >> SHIFT;
    m = (|q[127:63]) ? gtoe_pkg::INT64_MAX : q[63:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // magnitudes
      ua_r <= a_i[63] ? (~a_i + 64'd1) : a_i;
      ub_r <= b_i[63] ? (~b_i + 64'd1) : b_i;
      neg_r <= {neg_r[1:0], a_i[63] ^ b_i[63]};
      // partial products
      ll_r <= 64'(ua_r[31:0]) * 64'(ub_r[31:0]);
      lh_r <= 64'(ua_r[31:0]) * 64'(ub_r[63:32]);
      hl_r <= 64'(ua_r[63:32]) * 64'(ub_r[31:0]);
      hh_r <= 64'(ua_r[63:32]) * 64'(ub_r[63:32]);
      // full product plus rounding bias
      sum_r <= {64'd0, ll_r} + {32'd0, lh_r, 32'd0} + {32'd0, hl_r, 32'd0}
               + {hh_r, 64'd0} + RND;
      // sign back
      p_r <= neg_r[2] ? $signed(~m + 64'd1) : $signed(m);
    end
  end

  assign p_o = p_r;

endmodule

// ===== hw/rtl/ellipsoid_geodetic_to_ecef.sv =====
// ellipsoid_geodetic_to_ecef: top level of the geodetic to ecef converter
// depends on gtoe_pkg, gtoe_in_if, gtoe_out_if and the gtoe cell modules
//
// Usage: each item on in_item holds latitude and longitude as binary angles
// and a height in mm; each item on out_item holds ecef x, y, z in mm and the
// prime vertical radius. Every input item gives exactly one result item.
// Channels are valid/ready; an item moves when both are high.
// The apb port at cfg_ holds the semi-major axis (address 0) and the squared
// eccentricity in q40 (address 8); write them only while the pipeline is
// empty. pready is always high.
// Items pass through the cordic row, two rounding multipliers, 61 square
// root cells, 62 divider cells and two more multiplier levels. One item
// is accepted every cycle while out_item.ready is high, so throughput is
// one item per cycle.
// When the receiver stalls the whole pipeline holds, the result stays in
// the output register and in_item.ready drops until it is taken.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// wgs84 axis and eccentricity.
module ellipsoid_geodetic_to_ecef #(
  parameter int CORDIC_STAGES = gtoe_pkg::CORDIC_STAGES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  gtoe_in_if.sink           in_item,
  gtoe_out_if.source        out_item,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int SQ  = gtoe_pkg::SQRT_BITS;
  localparam int DV  = gtoe_pkg::QUO_BITS;
  localparam int ML  = gtoe_pkg::RMUL_LAT;
  localparam int D1  = 2 * ML + 1 + SQ + DV;
  localparam int LAT = CORDIC_STAGES + 21 + SQ + DV;

  // configuration registers
  logic [32:0] axis_r;
  logic [39:0] ecc_r;
  gtoe_pkg::reg_idx_t cfg_idx;

  assign cfg_idx = gtoe_pkg::reg_idx_t'(cfg_paddr[3]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r <= gtoe_pkg::AXIS_RESET;
      ecc_r <= gtoe_pkg::ECC_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_idx)
        gtoe_pkg::REG_AXIS: axis_r <= cfg_pwdata[32:0];
        gtoe_pkg::REG_ECC:  ecc_r <= cfg_pwdata[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      gtoe_pkg::REG_AXIS: cfg_prdata = {31'd0, axis_r};
      gtoe_pkg::REG_ECC:  cfg_prdata = {24'd0, ecc_r};
      default:            cfg_prdata = '0;
    endcase
  end

  // pipeline advance and valid line
  logic           adv;
  logic [LAT-1:0] valid_r;

  assign adv = !valid_r[LAT-1] || out_item.ready;
  assign in_item.ready = adv;
  assign out_item.valid = valid_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (adv) valid_r <= {valid_r[LAT-2:0], in_item.valid};
  end

  // quadrant fold into the right half plane
  gtoe_pkg::lane_t lat0_r, lon0_r, lat_fold, lon_fold;
  logic signed [31:0] h_r [CORDIC_STAGES+1];

  always_comb begin
    lat_fold.x = gtoe_pkg::INV_GAIN_Q60;
    lat_fold.y = '0;
    lat_fold.flip = in_item.latitude_angle[31] ^ in_item.latitude_angle[30];
    lat_fold.z = {in_item.latitude_angle[31] ^ lat_fold.flip,
                  in_item.latitude_angle[30:0], 32'd0};
    lon_fold.x = gtoe_pkg::INV_GAIN_Q60;
    lon_fold.y = '0;
    lon_fold.flip = in_item.longitude_angle[31] ^ in_item.longitude_angle[30];
    lon_fold.z = {in_item.longitude_angle[31] ^ lon_fold.flip,
                  in_item.longitude_angle[30:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lat0_r <= lat_fold;
      lon0_r <= lon_fold;
      h_r[0] <= in_item.height_mm;
      for (int i = 1; i <= CORDIC_STAGES; i++) h_r[i] <= h_r[i-1];
    end
  end

  // cordic rows, one for each angle
  gtoe_pkg::lane_t lat_w [CORDIC_STAGES+1];
  gtoe_pkg::lane_t lon_w [CORDIC_STAGES+1];

  assign lat_w[0] = lat0_r;
  assign lon_w[0] = lon0_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    gtoe_cordic_cell #(.STAGE(g)) u_lat (
      .clk(clk), .en(adv), .lane_i(lat_w[g]), .lane_o(lat_w[g+1])
    );
    gtoe_cordic_cell #(.STAGE(g)) u_lon (
      .clk(clk), .en(adv), .lane_i(lon_w[g]), .lane_o(lon_w[g+1])
    );
  end

  // unfold and side delay line
  gtoe_pkg::side_t side_nxt;
  gtoe_pkg::side_t sd_r [D1+6];

  always_comb begin
    side_nxt.clat = lat_w[CORDIC_STAGES].flip ? -lat_w[CORDIC_STAGES].x
                                              : lat_w[CORDIC_STAGES].x;
    side_nxt.slat = lat_w[CORDIC_STAGES].flip ? -lat_w[CORDIC_STAGES].y
                                              : lat_w[CORDIC_STAGES].y;
    side_nxt.clon = lon_w[CORDIC_STAGES].flip ? -lon_w[CORDIC_STAGES].x
                                              : lon_w[CORDIC_STAGES].x;
    side_nxt.slon = lon_w[CORDIC_STAGES].flip ? -lon_w[CORDIC_STAGES].y
                                              : lon_w[CORDIC_STAGES].y;
    side_nxt.h = h_r[CORDIC_STAGES];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= side_nxt;
      for (int i = 1; i < D1 + 6; i++) sd_r[i] <= sd_r[i-1];
    end
  end

  // sin^2 lat, then e2 * sin^2 lat
  logic signed [63:0] s2_p, s2_c, es2_p;
  logic [60:0]        w_r;
  logic signed [63:0] w_full;

  gtoe_rmul #(.SHIFT(60)) u_s2 (
    .clk(clk), .en(adv), .a_i(sd_r[0].slat), .b_i(sd_r[0].slat), .p_o(s2_p)
  );

  assign s2_c = (s2_p > gtoe_pkg::ONE_Q60) ? gtoe_pkg::ONE_Q60 : s2_p;

  gtoe_rmul #(.SHIFT(40)) u_es2 (
    .clk(clk), .en(adv), .a_i($signed({24'd0, ecc_r})), .b_i(s2_c), .p_o(es2_p)
  );

  assign w_full = gtoe_pkg::ONE_Q60 - es2_p;

  always_ff @(posedge clk) begin
    if (adv) w_r <= w_full[60:0];
  end

  // square root cells
  logic [gtoe_pkg::REM_W-1:0] sq_rem  [SQ+1];
  logic [SQ-1:0]              sq_root [SQ+1];

  assign sq_rem[0] = {1'b0, w_r, 60'd0};
  assign sq_root[0] = '0;

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    gtoe_sqrt_cell #(.BIT(SQ - 1 - g)) u_cell (
      .clk(clk), .en(adv),
      .rem_i(sq_rem[g]), .root_i(sq_root[g]),
      .rem_o(sq_rem[g+1]), .root_o(sq_root[g+1])
    );
  end

  // divider cells, axis * 2^68 over the root
  logic [gtoe_pkg::NUM_W-1:0] dv_rem [DV+1];
  logic [DV-1:0]              dv_quo [DV+1];
  logic [SQ-1:0]              dv_den [DV+1];

  assign dv_rem[0] = {axis_r, 68'd0};
  assign dv_quo[0] = '0;
  assign dv_den[0] = sq_root[SQ];

  for (genvar g = 0; g < DV; g++) begin : g_div
    gtoe_div_cell #(.BIT(DV - 1 - g)) u_cell (
      .clk(clk), .en(adv),
      .rem_i(dv_rem[g]), .quo_i(dv_quo[g]), .den_i(dv_den[g]),
      .rem_o(dv_rem[g+1]), .quo_o(dv_quo[g+1]), .den_o(dv_den[g+1])
    );
  end

  // (N + h) cos lat and N (1 - e2) + h
  logic signed [63:0] nq_s, nh, h8_a, h8_b, t_p, n1e_p, one_me2;
  logic signed [63:0] t_r, m_r;
  logic [DV-1:0]      nqd_r [9];

  assign nq_s = $signed({2'd0, dv_quo[DV]});
  assign h8_a = $signed({{24{sd_r[D1].h[31]}}, sd_r[D1].h, 8'd0});
  assign h8_b = $signed({{24{sd_r[D1+4].h[31]}}, sd_r[D1+4].h, 8'd0});
  assign nh = nq_s + h8_a;
  assign one_me2 = $signed(64'd1 << 40) - $signed({24'd0, ecc_r});

  gtoe_rmul #(.SHIFT(60)) u_t (
    .clk(clk), .en(adv), .a_i(nh), .b_i(sd_r[D1].clat), .p_o(t_p)
  );
  gtoe_rmul #(.SHIFT(40)) u_n1e (
    .clk(clk), .en(adv), .a_i(nq_s), .b_i(one_me2), .p_o(n1e_p)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r <= t_p;
      m_r <= n1e_p + h8_b;
      nqd_r[0] <= dv_quo[DV];
      for (int i = 1; i < 9; i++) nqd_r[i] <= nqd_r[i-1];
    end
  end

  // final products
  logic signed [63:0] x_p, y_p, z_p;

  gtoe_rmul #(.SHIFT(68)) u_x (
    .clk(clk), .en(adv), .a_i(t_r), .b_i(sd_r[D1+5].clon), .p_o(x_p)
  );
  gtoe_rmul #(.SHIFT(68)) u_y (
    .clk(clk), .en(adv), .a_i(t_r), .b_i(sd_r[D1+5].slon), .p_o(y_p)
  );
  gtoe_rmul #(.SHIFT(68)) u_z (
    .clk(clk), .en(adv), .a_i(m_r), .b_i(sd_r[D1+5].slat), .p_o(z_p)
  );

  // saturation into the output register
  function automatic logic [34:0] sat_xyz(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = v;
    if (s > gtoe_pkg::XYZ_MAX) s = gtoe_pkg::XYZ_MAX;
    if (s < gtoe_pkg::XYZ_MIN) s = gtoe_pkg::XYZ_MIN;
    return s[34:0];
  endfunction

  logic [34:0] x_r, y_r, z_r;
  logic [32:0] n_r;
  logic [DV-1:0] nr;
  logic [DV-9:0] nmm;

  always_comb begin
    nr = nqd_r[8] + DV'(128);
    nmm = nr[DV-1:8];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r <= sat_xyz(x_p);
      y_r <= sat_xyz(y_p);
      z_r <= sat_xyz(z_p);
      n_r <= (|nmm[DV-9:33]) ? gtoe_pkg::AXIS_MAX : nmm[32:0];
    end
  end

  assign out_item.ecef_x_mm = $signed(x_r);
  assign out_item.ecef_y_mm = $signed(y_r);
  assign out_item.ecef_z_mm = $signed(z_r);
  assign out_item.vertical_radius_mm = n_r;

endmodule
